>>> rtl/scfe_pkg.sv
// Shared types and constants of the sparse chip-firing engine.
package scfe_pkg;

	localparam int P_NODES   = 1024;
	localparam int P_ENTRIES = 8192;

	localparam int S_DW = 56;
	localparam int S_UW = 3;
	localparam int M_DW = 56;

	typedef enum logic [2:0] {
		FN_WR_VALUE  = 3'd0,
		FN_WR_DEGREE = 3'd1,
		FN_WR_START  = 3'd2,
		FN_WR_ENTRY  = 3'd3,
		FN_FIRE      = 3'd4,
		FN_READ      = 3'd5
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FIRE1,
		ST_FIRE2,
		ST_ENT,
		ST_ROW,
		ST_UPD,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic wr_item;
		logic rd_node;
		logic rd_cs1;
		logic mark_fire;
		logic ent_rd;
		logic row_rd;
		logic upd;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       node_ok;
		logic       elig;
		logic       walk_more;
		logic       walk_next;
		logic       out_free;
	} sts_t;

endpackage

>>> rtl/sparse_chip_firing_engine.sv
// Top level of the sparse chip-firing engine: controller and datapath.
//
// Channel  Direction  tdata (low bit up)                    tuser   tlast
// s_*      in         addr[12:0] data[44:13] row[54:45]     func    last_in_pass
// m_*      out        read_value[31:0] fired[32]            none    pass_done
//                     pass_fired[48:33]
//
// A write, a read, an unused code or a fire on a node out of range goes from decode to
// the finish step. A fire on a node in range reads the node and the column start and end,
// and if the node is eligible walks each column entry through the ENT, ROW and UPD steps,
// set by the single value memory port that each entry reads and then writes back.
// Reset clears the controller, the fire count and the output valid; memories are not cleared.
// A result that is not taken holds the next item in its final step until the output frees.
module sparse_chip_firing_engine import scfe_pkg::*; #(
	parameter int NODES   = P_NODES,
	parameter int ENTRIES = P_ENTRIES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [S_DW-1:0] s_tdata,  // addr, data, row, zero pad
	input  logic [S_UW-1:0] s_tuser,  // func
	input  logic            s_tlast,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [M_DW-1:0] m_tdata,  // read_value, fired, pass_fired, zero pad
	output logic            m_tlast
);

	cmd_t cmd;
	sts_t sts;

	scfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	scfe_dp #(
		.NODES   (NODES),
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

>>> rtl/scfe_ctrl.sv
// Controller state machine that sequences each transaction of the engine.
module scfe_ctrl import scfe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (sts.func)
					FN_WR_VALUE, FN_WR_DEGREE, FN_WR_START, FN_WR_ENTRY: begin
						cmd.wr_item = 1'b1;
						state_d     = ST_FINISH;
					end
					FN_READ: begin
						cmd.rd_node = 1'b1;
						state_d     = ST_FINISH;
					end
					FN_FIRE: begin
						if (sts.node_ok) begin
							cmd.rd_node = 1'b1;
							state_d     = ST_FIRE1;
						end else begin
							state_d = ST_FINISH;
						end
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_FIRE1: begin
				cmd.rd_cs1 = 1'b1;
				state_d    = ST_FIRE2;
			end
			ST_FIRE2: begin
				if (sts.elig) begin
					cmd.mark_fire = 1'b1;
					state_d       = sts.walk_more ? ST_ENT : ST_FINISH;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_ENT: begin
				cmd.ent_rd = 1'b1;
				state_d    = ST_ROW;
			end
			ST_ROW: begin
				cmd.row_rd = 1'b1;
				state_d    = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = sts.walk_next ? ST_ENT : ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/scfe_dp.sv
// Datapath of the engine: graph memories, column walk, fire counter and output register.
module scfe_dp import scfe_pkg::*; #(
	parameter int NODES   = P_NODES,
	parameter int ENTRIES = P_ENTRIES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [S_DW-1:0] s_tdata,
	input  logic [S_UW-1:0] s_tuser,
	input  logic            s_tlast,
	input  cmd_t            cmd,
	output sts_t            sts,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [M_DW-1:0] m_tdata,
	output logic            m_tlast
);

	localparam int NW = $clog2(NODES);
	localparam int CW = $clog2(NODES + 1);
	localparam int EW = $clog2(ENTRIES);
	localparam int SW = $clog2(ENTRIES + 1);

	logic [31:0]   val_mem [NODES];
	logic [31:0]   deg_mem [NODES];
	logic [SW-1:0] cs_mem  [NODES + 1];
	logic [9:0]    row_mem [ENTRIES];
	logic [31:0]   wgt_mem [ENTRIES];

	logic [2:0]    func_q;
	logic [12:0]   addr_q;
	logic [31:0]   data_q;
	logic [9:0]    row_in_q;
	logic          last_q;

	logic [31:0]   val_rd_q;
	logic [31:0]   deg_rd_q;
	logic [SW-1:0] cs_rd_q;
	logic [9:0]    erow_q;
	logic [31:0]   ewgt_q;
	logic [SW-1:0] p_q;
	logic          elig_q;
	logic          pos_q;
	logic          fired_q;
	logic [15:0]   cnt_q;

	logic          out_valid_q;
	logic [31:0]   out_rd_q;
	logic          out_fired_q;
	logic [15:0]   out_cnt_q;
	logic          out_done_q;

	logic          node_ok;
	logic          col_ok;
	logic          ent_ok;
	logic          row_ok;
	logic [NW-1:0] node_idx;
	logic [CW-1:0] col_idx;
	logic [CW-1:0] cs_raddr;
	logic [EW-1:0] ent_idx;
	logic [NW-1:0] row_idx;
	logic [NW-1:0] val_raddr;
	logic [31:0]   mag;
	logic [31:0]   upd_val;
	logic [SW-1:0] start_clamped;
	logic [SW:0]   p_inc;
	logic          is_fire;
	logic          done;
	logic [15:0]   cnt_next;

	assign node_ok   = 32'(addr_q) < 32'(NODES);
	assign col_ok    = 32'(addr_q) <= 32'(NODES);
	assign ent_ok    = 32'(addr_q) < 32'(ENTRIES);
	assign row_ok    = 32'(erow_q) < 32'(NODES);
	assign node_idx  = NW'(addr_q);
	assign col_idx   = CW'(addr_q);
	assign cs_raddr  = cmd.rd_cs1 ? col_idx + CW'(1) : col_idx;
	assign ent_idx   = EW'(addr_q);
	assign row_idx   = NW'(erow_q);
	assign val_raddr = cmd.row_rd ? row_idx : node_idx;
	assign mag       = val_rd_q[31] ? 32'd0 - val_rd_q : val_rd_q;
	assign upd_val   = pos_q ? val_rd_q - ewgt_q : val_rd_q + ewgt_q;
	assign p_inc     = {1'b0, p_q} + (SW + 1)'(1);

	always_comb begin
		if (data_q[31]) begin
			start_clamped = '0;
		end else if (data_q > 32'(ENTRIES)) begin
			start_clamped = SW'(ENTRIES);
		end else begin
			start_clamped = SW'(data_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= s_tuser;
			addr_q   <= s_tdata[12:0];
			data_q   <= s_tdata[44:13];
			row_in_q <= s_tdata[54:45];
			last_q   <= s_tlast;
			fired_q  <= 1'b0;
		end else if (cmd.mark_fire) begin
			fired_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_item && func_q == FN_WR_VALUE && node_ok) begin
			val_mem[node_idx] <= data_q;
		end else if (cmd.upd && row_ok) begin
			val_mem[row_idx] <= upd_val;
		end
		if (cmd.rd_node || cmd.row_rd) begin
			val_rd_q <= val_mem[val_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_item && func_q == FN_WR_DEGREE && node_ok) begin
			deg_mem[node_idx] <= data_q;
		end
		if (cmd.rd_node) begin
			deg_rd_q <= deg_mem[node_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_item && func_q == FN_WR_START && col_ok) begin
			cs_mem[col_idx] <= start_clamped;
		end
		if (cmd.rd_node || cmd.rd_cs1) begin
			cs_rd_q <= cs_mem[cs_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_item && func_q == FN_WR_ENTRY && ent_ok) begin
			row_mem[ent_idx] <= row_in_q;
			wgt_mem[ent_idx] <= data_q;
		end
		if (cmd.ent_rd) begin
			erow_q <= row_mem[EW'(p_q)];
			ewgt_q <= wgt_mem[EW'(p_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_cs1) begin
			p_q    <= cs_rd_q;
			elig_q <= !deg_rd_q[31] && deg_rd_q != 32'd0 && mag >= deg_rd_q;
			pos_q  <= val_rd_q != 32'd0 && !val_rd_q[31];
		end else if (cmd.upd) begin
			p_q <= SW'(p_inc);
		end
	end

	assign is_fire  = func_q == FN_FIRE;
	assign done     = is_fire && last_q;
	assign cnt_next = (is_fire && fired_q && cnt_q != 16'hFFFF) ? cnt_q + 16'd1 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				cnt_q       <= done ? 16'd0 : cnt_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_rd_q    <= (func_q == FN_READ && node_ok) ? val_rd_q : 32'd0;
			out_fired_q <= is_fire && fired_q;
			out_cnt_q   <= cnt_next;
			out_done_q  <= done;
		end
	end

	assign sts.func      = func_q;
	assign sts.node_ok   = node_ok;
	assign sts.elig      = elig_q;
	assign sts.walk_more = p_q < cs_rd_q;
	assign sts.walk_next = p_inc < {1'b0, cs_rd_q};
	assign sts.out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_cnt_q, out_fired_q, out_rd_q};
	assign m_tlast  = out_done_q;

endmodule

>>> rtl/scfe_checker.sv
// Port-level checker of the engine and its bind to the top level.
module scfe_checker import scfe_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            s_tvalid,
	input logic            s_tready,
	input logic [S_DW-1:0] s_tdata,
	input logic [S_UW-1:0] s_tuser,
	input logic            s_tlast,
	input logic            m_tvalid,
	input logic            m_tready,
	input logic [M_DW-1:0] m_tdata,
	input logic            m_tlast
);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Input accepted while a transaction is in progress.");

	a_fire_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[32] |-> m_tdata[48:33] != 16'd0)
		else $error("A fire was reported with a zero pass count.");

	a_fire_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'd0)
		else $error("A fire result carries a nonzero read value.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Output valid dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("Output payload changed while stalled.");

endmodule

bind sparse_chip_firing_engine scfe_checker u_scfe_checker (.*);
